FILE: src/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and helpers for the complex matrix multiply core
// Element, token and payload structs, command and register codes, and the
// round-and-saturate function used when results leave the cell chain.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int ACC_W     = 2 * ELEM_W + 2 + $clog2(MAX_DIM);
  localparam int CFG_W     = 4;
  localparam int PADDR_W   = 4;

  // Rounding bias: half of one output LSB
  localparam logic signed [ACC_W-1:0] RND_BIAS =
    (FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;

  // Commands
  localparam logic [1:0] CMD_WR_A = 2'd0;
  localparam logic [1:0] CMD_WR_B = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] re;
    logic signed [ELEM_W-1:0] im;
  } cplx_t;

  // Element of A travelling along the chain
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] k;
    cplx_t            a;
  } a_tok_t;

  // Write of one B element into the owning cell
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    cplx_t            d;
  } b_wr_t;

  // Result unload control
  typedef struct packed {
    logic load;
    logic shift;
  } res_ctl_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [2:0]               row;
    logic [2:0]               col;
    logic signed [ELEM_W-1:0] elem_re;
    logic signed [ELEM_W-1:0] elem_im;
  } cmm_in_t;

  typedef struct packed {
    logic [2:0]               out_row;
    logic [2:0]               out_col;
    logic signed [ELEM_W-1:0] prod_re;
    logic signed [ELEM_W-1:0] prod_im;
    logic                     last;
  } cmm_out_t;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // Round to nearest (ties up), drop fraction bits, saturate to 32 bits
  function automatic logic [ELEM_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sh;
    logic [ELEM_W-1:0]       r;
    sum = acc + RND_BIAS;
    sh  = sum >>> FRAC_BITS;
    if ((&sh[ACC_W-1:ELEM_W-1]) || !(|sh[ACC_W-1:ELEM_W-1])) begin
      r = sh[ELEM_W-1:0];
    end else if (sh[ACC_W-1]) begin
      r = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ELEM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/cmm_ram.sv
// ----------------------------------------------------------------------------
// cmm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cmm_cell.sv
// ----------------------------------------------------------------------------
// cmm_cell: one column cell of the product chain
// Holds one column of B and the accumulator of one result element. Takes an
// A element from its left neighbor, multiplies and accumulates, and passes
// the element right. Results shift left toward the output on unload.
// ----------------------------------------------------------------------------
module cmm_cell
  import cmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_col,
  input  b_wr_t            b_wr,
  input  a_tok_t           tok_in,
  output a_tok_t           tok_out,
  input  res_ctl_t         ctl,
  input  cplx_t            res_in,
  output cplx_t            res_out,
  output logic             done
);

  cplx_t                   b_col_r [MAX_DIM];
  a_tok_t                  tok_r;
  logic signed [2*ELEM_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                    s1_vld_r, s1_first_r, s1_last_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] term_re, term_im;
  logic                    done_r;
  cplx_t                   res_r, res_nxt;
  cplx_t                   b_sel;

  // Store this cell's column of B
  always_ff @(posedge clk) begin
    if (b_wr.we && b_wr.col == my_col) begin
      b_col_r[b_wr.row] <= b_wr.d;
    end
  end

  assign b_sel = b_col_r[tok_in.k];

  // Pass the A element to the right neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_in.vld;
    end
    tok_r.first <= tok_in.first;
    tok_r.last  <= tok_in.last;
    tok_r.k     <= tok_in.k;
    tok_r.a     <= tok_in.a;
  end

  assign tok_out = tok_r;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= tok_in.vld;
    end
    s1_first_r <= tok_in.first;
    s1_last_r  <= tok_in.last;
    p_rr_r     <= tok_in.a.re * b_sel.re;
    p_ii_r     <= tok_in.a.im * b_sel.im;
    p_ri_r     <= tok_in.a.re * b_sel.im;
    p_ir_r     <= tok_in.a.im * b_sel.re;
  end

  assign term_re = ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
  assign term_im = ACC_W'(p_ri_r) + ACC_W'(p_ir_r);

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      acc_re_r <= s1_first_r ? term_re : acc_re_r + term_re;
      acc_im_r <= s1_first_r ? term_im : acc_im_r + term_im;
    end
  end

  // Flag a finished sum until it is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (ctl.load) begin
      done_r <= 1'b0;
    end else if (s1_vld_r && s1_last_r) begin
      done_r <= 1'b1;
    end
  end

  assign done = done_r;

  // Load rounded result or shift from the right neighbor
  always_comb begin
    res_nxt = res_r;
    if (ctl.load) begin
      res_nxt.re = round_sat(acc_re_r);
      res_nxt.im = round_sat(acc_im_r);
    end else if (ctl.shift) begin
      res_nxt = res_in;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_out = res_r;

endmodule

FILE: src/complex_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// complex_matrix_multiply_core: complex matrix product in Q16.16
// Channel  | dir | handshake          | payload
// in       | in  | in_valid/in_ready  | cmm_in_t  (write A, write B, run)
// out      | out | out_valid/out_ready| cmm_out_t (one result element)
// config   | in  | APB psel/penable   | rows_a, inner_dim, cols_b
// A write or B write: accepted while idle, next item taken in the following cycle.
// Run: an accept, then per result row inner_dim A reads from the A RAM, the
// last element crossing the cell chain and settling, then cols_b output
// transfers, all with effective sizes.
// Output stalls hold the chain; no input is taken during a run.
// Reset: synchronous, active low; stores need writing before use.
// ----------------------------------------------------------------------------
module complex_matrix_multiply_core
  import cmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmm_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cmm_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] m_r, n_r, p_r;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             rd_vld_r, rd_first_r, rd_last_r;
  logic [IDX_W-1:0] rd_k_r;
  logic             in_acc, out_acc, cfg_wr, in_idx_ok;
  logic             k_end, j_end, i_end;
  logic [AW-1:0]    waddr, raddr;
  logic [2*ELEM_W-1:0] ram_rdata;
  a_tok_t           tok   [MAX_DIM+1];
  cplx_t            res   [MAX_DIM+1];
  logic [MAX_DIM-1:0] done;
  b_wr_t            b_wr;
  res_ctl_t         ctl;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_W'(MAX_DIM);
      inner_dim_r <= CFG_W'(MAX_DIM);
      cols_b_r    <= CFG_W'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS_A:    rows_a_r    <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_b_r    <= pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:    prdata = 32'(rows_a_r);
      REG_INNER_DIM: prdata = 32'(inner_dim_r);
      REG_COLS_B:    prdata = 32'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_idx_ok = (int'(in_data.row) < MAX_DIM) && (int'(in_data.col) < MAX_DIM);

  // A store
  assign waddr = AW'(int'(in_data.row) * MAX_DIM + int'(in_data.col));
  assign raddr = AW'(int'(i_r) * MAX_DIM + int'(k_r));

  cmm_ram #(
    .WIDTH(2 * ELEM_W),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_a_ram (
    .clk  (clk),
    .we   (in_acc && in_data.cmd == CMD_WR_A && in_idx_ok),
    .waddr(waddr),
    .wdata({in_data.elem_re, in_data.elem_im}),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // B writes go to the owning cell
  assign b_wr.we   = in_acc && in_data.cmd == CMD_WR_B && in_idx_ok;
  assign b_wr.row  = IDX_W'(in_data.row);
  assign b_wr.col  = IDX_W'(in_data.col);
  assign b_wr.d.re = in_data.elem_re;
  assign b_wr.d.im = in_data.elem_im;

  // Sequencer
  assign k_end = (DIM_W'(k_r) == n_r - DIM_W'(1));
  assign j_end = (DIM_W'(j_r) == p_r - DIM_W'(1));
  assign i_end = (DIM_W'(i_r) == m_r - DIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ctl.load  = 1'b0;
    ctl.shift = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.cmd == CMD_RUN) begin
          state_nxt = ST_ISSUE;
          i_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        k_nxt = k_r + IDX_W'(1);
        if (k_end) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (&done) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EMIT;
          j_nxt     = '0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          ctl.shift = 1'b1;
          j_nxt     = j_r + IDX_W'(1);
          if (j_end) begin
            k_nxt = '0;
            if (i_end) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = i_r + IDX_W'(1);
              state_nxt = ST_ISSUE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_ISSUE);
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    rd_first_r <= (k_r == '0);
    rd_last_r  <= k_end;
    rd_k_r     <= k_r;
  end

  // Latch effective dimensions at the start of a run
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      m_r <= eff_dim(rows_a_r);
      n_r <= eff_dim(inner_dim_r);
      p_r <= eff_dim(cols_b_r);
    end
  end

  // Cell chain
  assign tok[0].vld   = rd_vld_r;
  assign tok[0].first = rd_first_r;
  assign tok[0].last  = rd_last_r;
  assign tok[0].k     = rd_k_r;
  assign tok[0].a.re  = ram_rdata[2*ELEM_W-1:ELEM_W];
  assign tok[0].a.im  = ram_rdata[ELEM_W-1:0];
  assign res[MAX_DIM] = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    cmm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_col (IDX_W'(c)),
      .b_wr   (b_wr),
      .tok_in (tok[c]),
      .tok_out(tok[c+1]),
      .ctl    (ctl),
      .res_in (res[c+1]),
      .res_out(res[c]),
      .done   (done[c])
    );
  end

  // Result head comes from the first cell
  assign out_data.out_row = 3'(i_r);
  assign out_data.out_col = 3'(j_r);
  assign out_data.prod_re = res[0].re;
  assign out_data.prod_im = res[0].im;
  assign out_data.last    = i_end && j_end;

  logic unused_tail;
  assign unused_tail = tok[MAX_DIM].vld;

endmodule

FILE: src/cmm_checker.sv
// ----------------------------------------------------------------------------
// cmm_checker: port-level checks for the complex matrix multiply core
// Watches the input and output channels of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
module cmm_checker
  import cmm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input cmm_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input cmm_out_t out_data
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Drop input while results stream out
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during a run");

  // Close the run after the marked element
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> !out_valid)
    else $error("result after last element");

  // Advance into a run on a compute transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == CMD_RUN |=> !in_ready)
    else $error("input ready right after compute");

  // Stay idle after an element write
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == CMD_WR_A || in_data.cmd == CMD_WR_B)
      |=> in_ready)
    else $error("write left the idle state");

endmodule

bind complex_matrix_multiply_core cmm_checker u_cmm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
